>>> hw/rtl/bed_pkg.sv
// ----------------------------------------------------------------------------
// Backslash escape decoder package
// Shared transaction types, decoder modes, character codes and queue status.
// ----------------------------------------------------------------------------
package bed_pkg;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       is_arg_end;
    logic       is_final;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_item_t;

  // One entry of the job queue: one or two bytes to be sent.
  typedef struct packed {
    logic       two;
    logic [7:0] byte0;
    logic [7:0] byte1;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_ESCAPE = 2'd1,
    MODE_OCTAL  = 2'd2
  } mode_t;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_B  = 8'h62;
  localparam logic [7:0] CH_LOW_C  = 8'h63;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_V  = 8'h76;
  localparam logic [7:0] CH_BEL    = 8'h07;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_HT     = 8'h09;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;

endpackage

>>> hw/rtl/backslash_escape_decoder_core.sv
// ----------------------------------------------------------------------------
// Backslash escape decoder core
// Decodes echo-style backslash escapes in a stream of argument bytes.
//
//   Channel  Handshake          Payload
//   input    push / full        in_item  (text_byte, is_arg_end, is_final)
//   result   empty / pop        out_item (out_byte, last_of_run)
//
// An item is decoded in the cycle it is accepted and yields a job of zero,
// one or two bytes. The back end sends one byte per cycle while the
// result is popped, so the result port, not the input, is the limit.
// The input takes an item in every cycle while the job queue has room.
// Reset clears the decoder state, the queue and the result valid flag.
// ----------------------------------------------------------------------------
module backslash_escape_decoder_core #(
  parameter int MAX_OCTAL_DIGITS = 3,
  parameter int QUEUE_DEPTH      = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  bed_pkg::in_item_t  in_item,
  output logic               empty,
  input  logic               pop,
  output bed_pkg::out_item_t out_item
);

  bed_pkg::q_stat_t q_stat;
  bed_pkg::job_t    wr_job;
  bed_pkg::job_t    rd_job;
  logic             job_wr;
  logic             job_rd;

  bed_front #(
    .MAX_OCTAL_DIGITS(MAX_OCTAL_DIGITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_item (in_item),
    .q_stat  (q_stat),
    .job_wr  (job_wr),
    .job     (wr_job)
  );

  bed_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (job_wr),
    .wr_job (wr_job),
    .rd_en  (job_rd),
    .rd_job (rd_job),
    .q_stat (q_stat)
  );

  bed_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_stat   (q_stat),
    .rd_job   (rd_job),
    .rd_en    (job_rd),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

endmodule

>>> hw/rtl/bed_front.sv
// ----------------------------------------------------------------------------
// Backslash escape decoder front end
// Accepts input transactions, tracks the escape state and turns each item
// into at most one job of one or two output bytes for the queue.
// ----------------------------------------------------------------------------
module bed_front #(
  parameter int MAX_OCTAL_DIGITS = 3
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  bed_pkg::in_item_t in_item,
  input  bed_pkg::q_stat_t  q_stat,
  output logic              job_wr,
  output bed_pkg::job_t     job
);

  localparam logic [1:0] MaxDigits = 2'(MAX_OCTAL_DIGITS);

  bed_pkg::mode_t mode_r, mode_nxt;
  logic [1:0]     oct_cnt_r, oct_cnt_nxt;
  logic [8:0]     oct_val_r, oct_val_nxt;
  logic           stopped_r, stopped_nxt;

  logic       accept;
  logic [7:0] b;
  logic       is_digit;
  logic       is_bslash;
  logic [8:0] oct_val_inc;
  logic [1:0] oct_cnt_inc;
  logic       oct_done;
  logic [1:0] n_out;
  logic [7:0] e0, e1;

  assign full        = q_stat.full;
  assign accept      = push && !q_stat.full;
  assign b           = in_item.text_byte;
  assign is_digit    = b inside {[bed_pkg::CH_ZERO:bed_pkg::CH_SEVEN]};
  assign is_bslash   = (b == bed_pkg::CH_BSLASH);
  assign oct_val_inc = {oct_val_r[5:0], b[2:0]};
  assign oct_cnt_inc = oct_cnt_r + 2'd1;
  assign oct_done    = (oct_cnt_inc >= MaxDigits);

  always_comb begin
    mode_nxt    = mode_r;
    oct_cnt_nxt = oct_cnt_r;
    oct_val_nxt = oct_val_r;
    stopped_nxt = stopped_r;
    if (stopped_r) begin
      if (in_item.is_arg_end && in_item.is_final) begin
        mode_nxt    = bed_pkg::MODE_NORMAL;
        oct_cnt_nxt = 2'd0;
        oct_val_nxt = 9'd0;
        stopped_nxt = 1'b0;
      end
    end else if (in_item.is_arg_end) begin
      mode_nxt    = bed_pkg::MODE_NORMAL;
      oct_cnt_nxt = 2'd0;
      oct_val_nxt = 9'd0;
    end else begin
      case (mode_r)
        bed_pkg::MODE_ESCAPE: begin
          mode_nxt = bed_pkg::MODE_NORMAL;
          case (b)
            bed_pkg::CH_LOW_C: stopped_nxt = 1'b1;
            bed_pkg::CH_ZERO: begin
              mode_nxt    = bed_pkg::MODE_OCTAL;
              oct_cnt_nxt = 2'd0;
              oct_val_nxt = 9'd0;
            end
            default: ;
          endcase
        end
        bed_pkg::MODE_OCTAL: begin
          if (is_digit && !oct_done) begin
            oct_val_nxt = oct_val_inc;
            oct_cnt_nxt = oct_cnt_inc;
          end else begin
            mode_nxt    = (!is_digit && is_bslash) ? bed_pkg::MODE_ESCAPE
                                                   : bed_pkg::MODE_NORMAL;
            oct_cnt_nxt = 2'd0;
            oct_val_nxt = 9'd0;
          end
        end
        default: begin
          mode_nxt = is_bslash ? bed_pkg::MODE_ESCAPE : bed_pkg::MODE_NORMAL;
        end
      endcase
    end
  end

  always_comb begin
    n_out = 2'd0;
    e0    = b;
    e1    = b;
    if (stopped_r) begin
      n_out = 2'd0;
    end else if (in_item.is_arg_end) begin
      e1 = in_item.is_final ? bed_pkg::CH_LF : bed_pkg::CH_SPACE;
      case (mode_r)
        bed_pkg::MODE_ESCAPE: begin
          n_out = 2'd2;
          e0    = bed_pkg::CH_BSLASH;
        end
        bed_pkg::MODE_OCTAL: begin
          n_out = 2'd2;
          e0    = oct_val_r[7:0];
        end
        default: begin
          n_out = 2'd1;
          e0    = e1;
        end
      endcase
    end else begin
      case (mode_r)
        bed_pkg::MODE_ESCAPE: begin
          n_out = 2'd1;
          case (b)
            bed_pkg::CH_LOW_A:  e0 = bed_pkg::CH_BEL;
            bed_pkg::CH_LOW_B:  e0 = bed_pkg::CH_BS;
            bed_pkg::CH_LOW_F:  e0 = bed_pkg::CH_FF;
            bed_pkg::CH_LOW_N:  e0 = bed_pkg::CH_LF;
            bed_pkg::CH_LOW_R:  e0 = bed_pkg::CH_CR;
            bed_pkg::CH_LOW_T:  e0 = bed_pkg::CH_HT;
            bed_pkg::CH_LOW_V:  e0 = bed_pkg::CH_VT;
            bed_pkg::CH_BSLASH: e0 = bed_pkg::CH_BSLASH;
            bed_pkg::CH_LOW_C:  n_out = 2'd0;
            bed_pkg::CH_ZERO:   n_out = 2'd0;
            default: begin
              n_out = 2'd2;
              e0    = bed_pkg::CH_BSLASH;
            end
          endcase
        end
        bed_pkg::MODE_OCTAL: begin
          if (is_digit) begin
            n_out = oct_done ? 2'd1 : 2'd0;
            e0    = oct_val_inc[7:0];
          end else begin
            n_out = is_bslash ? 2'd1 : 2'd2;
            e0    = oct_val_r[7:0];
          end
        end
        default: begin
          n_out = is_bslash ? 2'd0 : 2'd1;
          e0    = b;
        end
      endcase
    end
  end

  assign job_wr    = accept && (n_out != 2'd0);
  assign job.two   = (n_out == 2'd2);
  assign job.byte0 = e0;
  assign job.byte1 = e1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= bed_pkg::MODE_NORMAL;
      oct_cnt_r <= 2'd0;
      oct_val_r <= 9'd0;
      stopped_r <= 1'b0;
    end else if (accept) begin
      mode_r    <= mode_nxt;
      oct_cnt_r <= oct_cnt_nxt;
      oct_val_r <= oct_val_nxt;
      stopped_r <= stopped_nxt;
    end
  end

endmodule

>>> hw/rtl/bed_queue.sv
// ----------------------------------------------------------------------------
// Backslash escape decoder job queue
// Short first-in first-out queue of byte jobs between front and back end.
// ----------------------------------------------------------------------------
module bed_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  bed_pkg::job_t    wr_job,
  input  logic             rd_en,
  output bed_pkg::job_t    rd_job,
  output bed_pkg::q_stat_t q_stat
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  bed_pkg::job_t   store_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;

  assign q_stat.full  = (cnt_r == FullCnt);
  assign q_stat.empty = (cnt_r == '0);
  assign rd_job       = store_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[wr_ptr_r] <= wr_job;
    end
  end

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FullCnt)
    else $error("Queue count exceeds its depth.");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !q_stat.full)
    else $error("Queue written while full.");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> !q_stat.empty)
    else $error("Queue read while empty.");
`endif

endmodule

>>> hw/rtl/bed_back.sv
// ----------------------------------------------------------------------------
// Backslash escape decoder back end
// Takes jobs from the queue and presents their bytes one transaction at a
// time from a holding register.
// ----------------------------------------------------------------------------
module bed_back (
  input  logic               clk,
  input  logic               rst_n,
  input  bed_pkg::q_stat_t   q_stat,
  input  bed_pkg::job_t      rd_job,
  output logic               rd_en,
  output logic               empty,
  input  logic               pop,
  output bed_pkg::out_item_t out_item
);

  bed_pkg::job_t job_r, job_nxt;
  logic          valid_r, valid_nxt;
  logic          sel_r, sel_nxt;
  logic          taken;

  assign taken = pop && valid_r;
  assign empty = !valid_r;

  assign out_item.out_byte    = sel_r ? job_r.byte1 : job_r.byte0;
  assign out_item.last_of_run = !job_r.two || sel_r;

  always_comb begin
    job_nxt   = job_r;
    valid_nxt = valid_r;
    sel_nxt   = sel_r;
    rd_en     = 1'b0;
    if (taken && job_r.two && !sel_r) begin
      sel_nxt = 1'b1;
    end else if (taken || !valid_r) begin
      rd_en     = !q_stat.empty;
      valid_nxt = !q_stat.empty;
      job_nxt   = rd_job;
      sel_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sel_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      sel_r   <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
  end

`ifndef ASSERT_OFF
  a_sel_two: assert property (@(posedge clk) disable iff (!rst_n)
    sel_r |-> (valid_r && job_r.two))
    else $error("Second byte selected on a job without one.");
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !pop) |=> (valid_r && $stable(sel_r)))
    else $error("Waiting result changed without being taken.");
  a_refill: assert property (@(posedge clk) disable iff (!rst_n)
    (!valid_r && !q_stat.empty) |-> rd_en)
    else $error("Back end idle while jobs wait.");
`endif

endmodule
